>>> rtl/core/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int SIZE_W   = 16;
  localparam int POS_W    = 18;
  localparam int REQ_W    = 15;
  localparam int OFF_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;
  } ffba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REQ_W-1:0]    payload_offset;
  } ffba_out_t;

  typedef struct packed {
    logic              free_mark;
    logic [SIZE_W-1:0] size;
  } ffba_hdr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_ISSUE,
    S_A_EVAL,
    S_A_SPLIT,
    S_F_MARK,
    S_C_ISSUE,
    S_C_EVAL_H,
    S_C_EVAL_N,
    S_FINISH
  } ffba_state_t;

endpackage

`default_nettype wire

>>> rtl/core/first_fit_block_allocator.sv
// An allocate walks headers from offset 0 (S_A_ISSUE, S_A_EVAL per header) and passes S_A_SPLIT on a
// split; a zero-byte request skips the walk. A free marks its header (S_F_MARK), then coalesces from
// offset 0 (S_C_ISSUE, S_C_EVAL_H, S_C_EVAL_N), but stops after the mark before the arena is built;
// an offset outside the arena skips the mark. One item at a time: walks read one header per cycle from
// the single read port; a result in S_FINISH stalls the next item until the output register takes it.
// Reset clears the control state, the arena-ready flag and the output valid, not the header memory.
`default_nettype none

module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = 32768,
  parameter int HEADER_BYTES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ffba_pkg::ffba_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ffba_pkg::ffba_out_t     out_data
);
  import ffba_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam logic [POS_W-1:0]  ARENA_P   = POS_W'(ARENA_BYTES);
  localparam logic [POS_W-1:0]  HDR_P     = POS_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_S     = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

  ffba_hdr_t hdr_mem [ARENA_BYTES];
  ffba_hdr_t mem_rdata;
  logic      mem_we;
  logic      mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  ffba_hdr_t mem_wdata;

  ffba_state_t state_r, state_nxt;
  logic        ready_r, ready_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [AW-1:0]    h_r, h_nxt;
  ffba_hdr_t        hdr_r, hdr_nxt;
  ffba_out_t        pend_r, pend_nxt;
  logic             out_valid_r;
  ffba_out_t        out_data_r;

  logic              in_xfer;
  logic              out_load;
  logic [POS_W-1:0]  h_pos;
  logic [POS_W-1:0]  rd_next;
  logic [POS_W-1:0]  n_pos;
  logic [POS_W-1:0]  after_n;
  logic [POS_W-1:0]  off_pos;
  logic [POS_W-1:0]  mark_pos;
  logic [POS_W-1:0]  rem_pos;
  logic [POS_W-1:0]  pay_pos;
  logic              off_bad;
  logic              fit;
  logic              exact;
  logic              split_ok;
  logic [SIZE_W-1:0] rem_size;
  logic [SIZE_W-1:0] merged;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= hdr_mem[mem_raddr];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign h_pos    = POS_W'(h_r);
  assign rd_next  = h_pos + HDR_P + POS_W'(mem_rdata.size);
  assign n_pos    = h_pos + HDR_P + POS_W'(hdr_r.size);
  assign after_n  = n_pos + HDR_P + POS_W'(mem_rdata.size);
  assign off_pos  = POS_W'(in_data.block_offset);
  assign off_bad  = (off_pos < HDR_P) || (off_pos > ARENA_P);
  assign mark_pos = off_pos - HDR_P;
  assign rem_pos  = h_pos + HDR_P + POS_W'(req_r);
  assign pay_pos  = h_pos + HDR_P;
  assign fit      = mem_rdata.free_mark && (mem_rdata.size >= SIZE_W'(req_r));
  assign exact    = (mem_rdata.size == SIZE_W'(req_r));
  assign split_ok = (POS_W'(mem_rdata.size) > (POS_W'(req_r) + HDR_P));
  assign rem_size = mem_rdata.size - SIZE_W'(req_r) - HDR_S;
  assign merged   = hdr_r.size + HDR_S + mem_rdata.size;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.op == OP_ALLOC) begin
            state_nxt = (in_data.request_bytes == '0) ? S_FINISH : S_A_ISSUE;
          end else begin
            state_nxt = off_bad ? S_FINISH : S_F_MARK;
          end
        end
      end
      S_A_ISSUE: state_nxt = S_A_EVAL;
      S_A_EVAL: begin
        if (fit) begin
          state_nxt = (!exact && split_ok) ? S_A_SPLIT : S_FINISH;
        end else if (rd_next >= ARENA_P) begin
          state_nxt = S_FINISH;
        end
      end
      S_A_SPLIT: state_nxt = S_FINISH;
      S_F_MARK:  state_nxt = ready_r ? S_C_ISSUE : S_FINISH;
      S_C_ISSUE: state_nxt = S_C_EVAL_H;
      S_C_EVAL_H: begin
        if (rd_next >= ARENA_P) begin
          state_nxt = S_FINISH;
        end else if (mem_rdata.free_mark) begin
          state_nxt = S_C_EVAL_N;
        end
      end
      S_C_EVAL_N: begin
        if (after_n >= ARENA_P) begin
          state_nxt = S_FINISH;
        end else if (!mem_rdata.free_mark) begin
          state_nxt = S_C_EVAL_H;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = h_r;
    mem_wdata = hdr_r;
    mem_re    = 1'b0;
    mem_raddr = h_r;
    h_nxt     = h_r;
    hdr_nxt   = hdr_r;
    req_nxt   = req_r;
    pend_nxt  = pend_r;
    ready_nxt = ready_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_data.request_bytes;
          h_nxt   = '0;
          if (in_data.op == OP_ALLOC) begin
            pend_nxt = '{status: ST_NO_SPACE, payload_offset: '0};
            if (!ready_r) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = '{free_mark: 1'b1, size: INIT_SIZE};
              ready_nxt = 1'b1;
            end
          end else begin
            pend_nxt = '{status: off_bad ? ST_RANGE : ST_DONE, payload_offset: '0};
            h_nxt    = AW'(mark_pos);
            if (!off_bad) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(mark_pos);
            end
          end
        end
      end
      S_A_ISSUE: begin
        mem_re = 1'b1;
      end
      S_A_EVAL: begin
        if (fit) begin
          if (exact) begin
            mem_we    = 1'b1;
            mem_wdata = '{free_mark: 1'b0, size: SIZE_W'(req_r)};
            pend_nxt  = '{status: ST_DONE, payload_offset: REQ_W'(pay_pos)};
          end else if (split_ok) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rem_pos);
            mem_wdata = '{free_mark: 1'b1, size: rem_size};
            pend_nxt  = '{status: ST_DONE, payload_offset: REQ_W'(pay_pos)};
          end
        end else if (rd_next < ARENA_P) begin
          h_nxt     = AW'(rd_next);
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_next);
        end
      end
      S_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{free_mark: 1'b0, size: SIZE_W'(req_r)};
      end
      S_F_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = '{free_mark: 1'b1, size: mem_rdata.size};
        h_nxt     = '0;
      end
      S_C_ISSUE: begin
        mem_re = 1'b1;
      end
      S_C_EVAL_H: begin
        hdr_nxt = mem_rdata;
        if (rd_next < ARENA_P) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_next);
          if (!mem_rdata.free_mark) begin
            h_nxt = AW'(rd_next);
          end
        end
      end
      S_C_EVAL_N: begin
        if (mem_rdata.free_mark) begin
          mem_we    = 1'b1;
          mem_wdata = '{free_mark: 1'b1, size: merged};
          hdr_nxt   = '{free_mark: 1'b1, size: merged};
        end else begin
          h_nxt = AW'(after_n);
        end
        if (after_n < ARENA_P) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(after_n);
        end
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    hdr_r   <= hdr_nxt;
    req_r   <= req_nxt;
    pend_r  <= pend_nxt;
    if (out_load) begin
      out_data_r <= pend_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ffba_checker.sv
`default_nettype none

module ffba_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire ffba_pkg::ffba_in_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ffba_pkg::ffba_out_t out_data
);
  import ffba_pkg::*;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Items are handled one at a time, so an input transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input transfer while an item is in work");

  // Only a successful allocate carries an offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.payload_offset == '0)
    else $error("offset reported without an allocation");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_DONE || out_data.status == ST_NO_SPACE ||
                  out_data.status == ST_RANGE)
    else $error("unknown status code");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire
